### design/mhdc_pkg.sv
// ----------------------------------------------------------------------------
// mhdc_pkg
// Shared constants for the MHD conservative-to-primitive converter: the
// width and reset value of the gamma-minus-one register.
// ----------------------------------------------------------------------------
package mhdc_pkg;

    localparam int GAMMA_BITS = 18;
    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 18'd43691;

endpackage

### design/mhdc_cell_if.sv
// ----------------------------------------------------------------------------
// mhdc_cell_if
// Valid/ready channel carrying one conservative cell state.
// ----------------------------------------------------------------------------
interface mhdc_cell_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] density;
    logic signed [WORD_BITS-1:0] momentum_x;
    logic signed [WORD_BITS-1:0] momentum_y;
    logic signed [WORD_BITS-1:0] momentum_z;
    logic signed [WORD_BITS-1:0] field_x;
    logic signed [WORD_BITS-1:0] field_y;
    logic signed [WORD_BITS-1:0] field_z;
    logic signed [WORD_BITS-1:0] total_energy;
    logic signed [WORD_BITS-1:0] cleaning_scalar;
    logic signed [WORD_BITS-1:0] eps_plus;
    logic signed [WORD_BITS-1:0] eps_minus;

    modport source (
        output valid, density, momentum_x, momentum_y, momentum_z, field_x, field_y,
               field_z, total_energy, cleaning_scalar, eps_plus, eps_minus,
        input  ready
    );
    modport sink (
        input  valid, density, momentum_x, momentum_y, momentum_z, field_x, field_y,
               field_z, total_energy, cleaning_scalar, eps_plus, eps_minus,
        output ready
    );
endinterface

### design/mhdc_prim_if.sv
// ----------------------------------------------------------------------------
// mhdc_prim_if
// Valid/ready channel carrying one primitive cell state and its fault flag.
// ----------------------------------------------------------------------------
interface mhdc_prim_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] density_out;
    logic signed [WORD_BITS-1:0] velocity_x;
    logic signed [WORD_BITS-1:0] velocity_y;
    logic signed [WORD_BITS-1:0] velocity_z;
    logic signed [WORD_BITS-1:0] field_x_out;
    logic signed [WORD_BITS-1:0] field_y_out;
    logic signed [WORD_BITS-1:0] field_z_out;
    logic signed [WORD_BITS-1:0] pressure;
    logic signed [WORD_BITS-1:0] cleaning_scalar_out;
    logic signed [WORD_BITS-1:0] eps_plus_out;
    logic signed [WORD_BITS-1:0] eps_minus_out;
    logic                        density_fault;

    modport source (
        output valid, density_out, velocity_x, velocity_y, velocity_z, field_x_out,
               field_y_out, field_z_out, pressure, cleaning_scalar_out, eps_plus_out,
               eps_minus_out, density_fault,
        input  ready
    );
    modport sink (
        input  valid, density_out, velocity_x, velocity_y, velocity_z, field_x_out,
               field_y_out, field_z_out, pressure, cleaning_scalar_out, eps_plus_out,
               eps_minus_out, density_fault,
        output ready
    );
endinterface

### design/mhdc_cfg_if.sv
// ----------------------------------------------------------------------------
// mhdc_cfg_if
// Valid/ready write channel for the gamma-minus-one register.
// ----------------------------------------------------------------------------
interface mhdc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mhdc_pkg::GAMMA_BITS-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### design/mhdc_square_sum.sv
// ----------------------------------------------------------------------------
// mhdc_square_sum
// Two-stage sum of three squared magnitudes: squares, then their sum.
// ----------------------------------------------------------------------------
module mhdc_square_sum #(
    parameter int WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [WORD_BITS-1:0]     mag_a,
    input  logic [WORD_BITS-1:0]     mag_b,
    input  logic [WORD_BITS-1:0]     mag_c,
    output logic [2*WORD_BITS-1:0]   sum
);
    localparam int SW = 2 * WORD_BITS;

    logic [SW-1:0] sq_a_reg;
    logic [SW-1:0] sq_b_reg;
    logic [SW-1:0] sq_c_reg;
    logic [SW-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_a_reg <= mag_a * mag_a;
            sq_b_reg <= mag_b * mag_b;
            sq_c_reg <= mag_c * mag_c;
            // Each square is at most a quarter of the range, so the sum cannot wrap.
            sum_reg  <= sq_a_reg + sq_b_reg + sq_c_reg;
        end
    end

    assign sum = sum_reg;

endmodule

### design/mhdc_divider.sv
// ----------------------------------------------------------------------------
// mhdc_divider
// Pipelined restoring divider: one quotient bit per stage, unsigned operands,
// divisor nonzero.
// ----------------------------------------------------------------------------
module mhdc_divider #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 31
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] numerator,
    input  logic [DEN_BITS-1:0] divisor,
    output logic [NUM_BITS-1:0] quotient
);
    logic [DEN_BITS-1:0] rem_reg [NUM_BITS];
    logic [DEN_BITS-1:0] den_reg [NUM_BITS];
    logic [NUM_BITS-1:0] nq_reg  [NUM_BITS];

    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_stage
        logic [DEN_BITS-1:0] rem_in;
        logic [DEN_BITS-1:0] den_in;
        logic [NUM_BITS-1:0] nq_in;
        logic [DEN_BITS:0]   trial;
        logic [DEN_BITS:0]   diff;
        logic                take;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign den_in = divisor;
            assign nq_in  = numerator;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign nq_in  = nq_reg[k-1];
        end

        // The partial remainder stays below the divisor, so a missing borrow
        // leaves the top bit of the difference clear.
        assign trial = {rem_in, nq_in[NUM_BITS-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = ~diff[DEN_BITS];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                den_reg[k] <= den_in;
                nq_reg[k]  <= {nq_in[NUM_BITS-2:0], take};
            end
        end
    end

    assign quotient = nq_reg[NUM_BITS-1];

endmodule

### design/mhdc_pressure.sv
// ----------------------------------------------------------------------------
// mhdc_pressure
// Five-stage pressure path: clamp the kinetic and magnetic terms, form the
// internal energy, multiply by gamma minus one in two partial products, sum,
// then shift and saturate to the word.
// ----------------------------------------------------------------------------
module mhdc_pressure #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [2*WORD_BITS-1:0]              kin_quot,
    input  logic [2*WORD_BITS-1:0]              field_sum,
    input  logic                                fault,
    input  logic signed [WORD_BITS-1:0]         energy,
    input  logic [mhdc_pkg::GAMMA_BITS-1:0]     gamma_m1,
    output logic signed [WORD_BITS-1:0]         pressure
);
    import mhdc_pkg::*;

    localparam int QW = 2 * WORD_BITS;
    localparam int CW = WORD_BITS + FRACTION_BITS + 2;
    localparam int IW = CW + 1;
    localparam int HB = IW / 2;
    localparam int HW = IW - HB;
    localparam int LW = HB + GAMMA_BITS;
    localparam int UW = HW + GAMMA_BITS + 1;
    localparam int PW = IW + GAMMA_BITS + 1;
    localparam logic [QW-1:0] CAP = QW'(1) << (WORD_BITS + FRACTION_BITS + 1);
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [CW-1:0]              kc_reg;
    logic [CW-1:0]              bc_reg;
    logic signed [WORD_BITS-1:0] e_reg;
    logic signed [IW-1:0]       inner_reg;
    logic [LW-1:0]              plo_reg;
    logic signed [UW-1:0]       phi_reg;
    logic signed [PW-1:0]       sum_reg;
    logic signed [WORD_BITS-1:0] p_reg;

    logic [QW-1:0]              b_shift;
    logic [CW-1:0]              kc_next;
    logic [CW-1:0]              bc_next;
    logic [CW:0]                kb_sum;
    logic signed [IW-1:0]       inner_next;
    logic signed [PW-1:0]       shifted;
    logic                       in_range;

    always_comb
    begin
        b_shift = field_sum >> FRACTION_BITS;
        if (fault)
            kc_next = '0;
        else if (kin_quot > CAP)
            kc_next = CAP[CW-1:0];
        else
            kc_next = kin_quot[CW-1:0];
        bc_next = (b_shift > CAP) ? CAP[CW-1:0] : b_shift[CW-1:0];

        kb_sum     = {1'b0, kc_reg} + {1'b0, bc_reg};
        inner_next = IW'(e_reg) - $signed({1'b0, kb_sum[CW:1]});

        shifted  = sum_reg >>> FRACTION_BITS;
        in_range = (&shifted[PW-1:WORD_BITS-1]) || ~(|shifted[PW-1:WORD_BITS-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kc_reg    <= kc_next;
            bc_reg    <= bc_next;
            e_reg     <= energy;
            inner_reg <= inner_next;
            plo_reg   <= inner_reg[HB-1:0] * gamma_m1;
            phi_reg   <= $signed(inner_reg[IW-1:HB]) * $signed({1'b0, gamma_m1});
            sum_reg   <= (PW'(phi_reg) <<< HB) + $signed(PW'(plo_reg));
            if (in_range)
                p_reg <= shifted[WORD_BITS-1:0];
            else
                p_reg <= shifted[PW-1] ? W_MIN : W_MAX;
        end
    end

    assign pressure = p_reg;

endmodule

### design/mhd_conservative_to_primitive.sv
// ----------------------------------------------------------------------------
// mhd_conservative_to_primitive
// Converts one ideal-MHD cell state from conservative to primitive form in
// signed fixed point, with velocities from pipelined dividers and a
// saturated pressure.
//
//   channel   modport  carries
//   cell_in   sink     conservative cell state, one item per cell
//   prim_out  source   primitive cell state and density fault flag
//   cfg       sink     gamma minus one, unsigned, always ready
//
// One item enters per cycle while the output is not stalled. The pipeline depth is
// set mainly by the bit-per-stage dividers for velocity and kinetic term.
// Reset clears all valid bits and loads gamma minus one with its default.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mhd_conservative_to_primitive #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    mhdc_cell_if.sink    cell_in,
    mhdc_prim_if.source  prim_out,
    mhdc_cfg_if.sink     cfg
);
    import mhdc_pkg::*;

    // FRACTION_BITS must stay at most WORD_BITS - 2.
    localparam int W      = WORD_BITS;
    localparam int QW     = 2 * WORD_BITS;
    localparam int SQ_AT  = 2;
    localparam int DIV_AT = SQ_AT + QW;
    localparam int LAST   = DIV_AT + 5;
    localparam logic [QW-1:0] V_LIMIT = QW'(1) << (W - 1);
    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0]  rho;
        logic          fault;
        logic          sgn_x;
        logic          sgn_y;
        logic          sgn_z;
        logic [W-1:0]  mag_mx;
        logic [W-1:0]  mag_my;
        logic [W-1:0]  mag_mz;
        logic [W-1:0]  mag_bx;
        logic [W-1:0]  mag_by;
        logic [W-1:0]  mag_bz;
        logic [W-1:0]  energy;
        logic [W-1:0]  bx;
        logic [W-1:0]  by;
        logic [W-1:0]  bz;
        logic [W-1:0]  psi;
        logic [W-1:0]  epp;
        logic [W-1:0]  epm;
        logic [QW-1:0] bsum;
        logic [W-1:0]  vx;
        logic [W-1:0]  vy;
        logic [W-1:0]  vz;
    } side_t;

    logic [GAMMA_BITS-1:0] gamma_reg;
    logic                  vld_reg [LAST+1];
    side_t                 stg_reg [LAST+1];
    side_t                 stg_next [LAST];
    side_t                 entry;
    logic                  adv;

    logic [QW-1:0]         ksum;
    logic [QW-1:0]         bsum;
    logic [W-2:0]          divisor;
    logic [QW-1:0]         quot_x;
    logic [QW-1:0]         quot_y;
    logic [QW-1:0]         quot_z;
    logic [QW-1:0]         quot_k;
    logic signed [W-1:0]   p_word;

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    function automatic logic [W-1:0] vel_sat(input logic [QW-1:0] q, input logic neg,
                                             input logic flt);
        logic [W-1:0] r;
        if (flt)
            r = '0;
        else if (!neg)
            r = (q >= V_LIMIT) ? W_MAX : q[W-1:0];
        else
            r = (q > V_LIMIT) ? W_MIN : (~q[W-1:0] + W'(1));
        return r;
    endfunction

    assign adv           = ~vld_reg[LAST] | prim_out.ready;
    assign cell_in.ready = adv;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= GAMMA_RESET;
        else if (cfg.valid)
            gamma_reg <= cfg.data;
    end

    always_comb
    begin
        entry        = '0;
        entry.rho    = cell_in.density;
        entry.fault  = cell_in.density[W-1] || (cell_in.density == '0);
        entry.sgn_x  = cell_in.momentum_x[W-1];
        entry.sgn_y  = cell_in.momentum_y[W-1];
        entry.sgn_z  = cell_in.momentum_z[W-1];
        entry.mag_mx = magnitude(cell_in.momentum_x);
        entry.mag_my = magnitude(cell_in.momentum_y);
        entry.mag_mz = magnitude(cell_in.momentum_z);
        entry.mag_bx = magnitude(cell_in.field_x);
        entry.mag_by = magnitude(cell_in.field_y);
        entry.mag_bz = magnitude(cell_in.field_z);
        entry.energy = cell_in.total_energy;
        entry.bx     = cell_in.field_x;
        entry.by     = cell_in.field_y;
        entry.bz     = cell_in.field_z;
        entry.psi    = cell_in.cleaning_scalar;
        entry.epp    = cell_in.eps_plus;
        entry.epm    = cell_in.eps_minus;
    end

    // Each stage copies the one before it; the field square sum and the saturated
    // velocities join the record at the stage where they are ready.
    for (genvar k = 0; k < LAST; k++)
    begin : g_side
        always_comb
        begin
            stg_next[k] = stg_reg[k];
            if (k == SQ_AT)
                stg_next[k].bsum = bsum;
            if (k == DIV_AT)
            begin
                stg_next[k].vx = vel_sat(quot_x, stg_reg[k].sgn_x, stg_reg[k].fault);
                stg_next[k].vy = vel_sat(quot_y, stg_reg[k].sgn_y, stg_reg[k].fault);
                stg_next[k].vz = vel_sat(quot_z, stg_reg[k].sgn_z, stg_reg[k].fault);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stg_reg[k+1] <= stg_next[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (adv)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stg_reg[0] <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= cell_in.valid;
    end

    mhdc_square_sum #(.WORD_BITS(W)) u_mom_sq (
        .clk   (clk),
        .en    (adv),
        .mag_a (stg_reg[0].mag_mx),
        .mag_b (stg_reg[0].mag_my),
        .mag_c (stg_reg[0].mag_mz),
        .sum   (ksum)
    );

    mhdc_square_sum #(.WORD_BITS(W)) u_fld_sq (
        .clk   (clk),
        .en    (adv),
        .mag_a (stg_reg[0].mag_bx),
        .mag_b (stg_reg[0].mag_by),
        .mag_c (stg_reg[0].mag_bz),
        .sum   (bsum)
    );

    // A faulty density divides by one; its results are discarded downstream.
    assign divisor = stg_reg[SQ_AT].fault ? (W-1)'(1) : stg_reg[SQ_AT].rho[W-2:0];

    mhdc_divider #(.NUM_BITS(QW), .DEN_BITS(W-1)) u_div_x (
        .clk       (clk),
        .en        (adv),
        .numerator (QW'(stg_reg[SQ_AT].mag_mx) << FRACTION_BITS),
        .divisor   (divisor),
        .quotient  (quot_x)
    );

    mhdc_divider #(.NUM_BITS(QW), .DEN_BITS(W-1)) u_div_y (
        .clk       (clk),
        .en        (adv),
        .numerator (QW'(stg_reg[SQ_AT].mag_my) << FRACTION_BITS),
        .divisor   (divisor),
        .quotient  (quot_y)
    );

    mhdc_divider #(.NUM_BITS(QW), .DEN_BITS(W-1)) u_div_z (
        .clk       (clk),
        .en        (adv),
        .numerator (QW'(stg_reg[SQ_AT].mag_mz) << FRACTION_BITS),
        .divisor   (divisor),
        .quotient  (quot_z)
    );

    mhdc_divider #(.NUM_BITS(QW), .DEN_BITS(W-1)) u_div_k (
        .clk       (clk),
        .en        (adv),
        .numerator (ksum),
        .divisor   (divisor),
        .quotient  (quot_k)
    );

    mhdc_pressure #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_pressure (
        .clk       (clk),
        .en        (adv),
        .kin_quot  (quot_k),
        .field_sum (stg_reg[DIV_AT].bsum),
        .fault     (stg_reg[DIV_AT].fault),
        .energy    (stg_reg[DIV_AT].energy),
        .gamma_m1  (gamma_reg),
        .pressure  (p_word)
    );

    assign prim_out.valid               = vld_reg[LAST];
    assign prim_out.density_out         = stg_reg[LAST].rho;
    assign prim_out.velocity_x          = stg_reg[LAST].vx;
    assign prim_out.velocity_y          = stg_reg[LAST].vy;
    assign prim_out.velocity_z          = stg_reg[LAST].vz;
    assign prim_out.field_x_out         = stg_reg[LAST].bx;
    assign prim_out.field_y_out         = stg_reg[LAST].by;
    assign prim_out.field_z_out         = stg_reg[LAST].bz;
    assign prim_out.pressure            = p_word;
    assign prim_out.cleaning_scalar_out = stg_reg[LAST].psi;
    assign prim_out.eps_plus_out        = stg_reg[LAST].epp;
    assign prim_out.eps_minus_out       = stg_reg[LAST].epm;
    assign prim_out.density_fault       = stg_reg[LAST].fault;

`ifndef SYNTHESIS
    a_fault_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        prim_out.valid && prim_out.density_fault |->
            prim_out.velocity_x == '0 && prim_out.velocity_y == '0 &&
            prim_out.velocity_z == '0)
        else $error("velocities not zero on a density fault");

    a_fault_matches_rho: assert property (@(posedge clk) disable iff (!rst_n)
        prim_out.valid |-> prim_out.density_fault ==
            (prim_out.density_out[W-1] || prim_out.density_out == '0))
        else $error("density fault flag does not match density");

    a_stall_holds_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        prim_out.valid && !prim_out.ready |=> $stable(prim_out.pressure))
        else $error("pressure changed during a stall");
`endif

endmodule

### tb/sv/mhd_conservative_to_primitive_checker.sv
// ----------------------------------------------------------------------------
// mhd_conservative_to_primitive_checker
// Watches the cell, primitive and configuration channels, predicts the
// primitive state of every accepted cell and compares each result item,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mhd_conservative_to_primitive_checker (
    input  logic  clk,
    input  logic  rst_n,
    mhdc_cell_if  cons,
    mhdc_prim_if  prim,
    mhdc_cfg_if   cfg,
    output int    fails,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] pressure;
        logic signed [31:0] psi;
        logic signed [31:0] eps_p;
        logic signed [31:0] eps_m;
        logic               fault;
    } prim_state_t;

    localparam logic signed [127:0] WORD_MAX = 128'sd2147483647;
    localparam logic signed [127:0] WORD_MIN = -128'sd2147483648;
    localparam logic signed [127:0] TERM_CAP = 128'sd1 <<< 49;

    logic [mhdc_pkg::GAMMA_BITS-1:0] gamma_m1;
    prim_state_t                     expected_prims[$];

    function automatic logic signed [31:0] clip_word(logic signed [127:0] v);
        if (v > WORD_MAX) return WORD_MAX[31:0];
        if (v < WORD_MIN) return WORD_MIN[31:0];
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] divide_velocity(logic signed [31:0] m,
                                                           logic signed [127:0] rho);
        logic signed [127:0] mw;
        logic signed [127:0] q;
        begin
            mw = m;
            if (mw < 0) mw = -mw;
            q = (mw <<< 16) / rho;
            if (m < 0) q = -q;
            return clip_word(q);
        end
    endfunction

    function automatic prim_state_t convert_cell(logic signed [31:0] f[11],
                                                 logic [mhdc_pkg::GAMMA_BITS-1:0] g);
        prim_state_t         r;
        logic signed [127:0] rho, s, kin, mag2, inner, gw, p;
        logic                bad;
        begin
            rho  = f[0];
            bad  = (rho <= 0);
            s    = 128'(f[4]);
            mag2 = s * s;
            s    = 128'(f[5]);
            mag2 = mag2 + s * s;
            s    = 128'(f[6]);
            mag2 = mag2 + s * s;
            mag2 = mag2 >>> 16;
            if (mag2 > TERM_CAP) mag2 = TERM_CAP;
            kin = 0;
            if (!bad)
            begin
                s   = 128'(f[1]);
                kin = s * s;
                s   = 128'(f[2]);
                kin = kin + s * s;
                s   = 128'(f[3]);
                kin = kin + s * s;
                kin = kin / rho;
                if (kin > TERM_CAP) kin = TERM_CAP;
            end
            inner = 128'(f[7]) - ((kin + mag2) >>> 1);
            gw    = {110'b0, g};
            p     = (inner * gw) >>> 16;
            r.density  = f[0];
            r.vel_x    = bad ? '0 : divide_velocity(f[1], rho);
            r.vel_y    = bad ? '0 : divide_velocity(f[2], rho);
            r.vel_z    = bad ? '0 : divide_velocity(f[3], rho);
            r.bx       = f[4];
            r.by       = f[5];
            r.bz       = f[6];
            r.pressure = clip_word(p);
            r.psi      = f[8];
            r.eps_p    = f[9];
            r.eps_m    = f[10];
            r.fault    = bad;
            return r;
        end
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fails++;
        end
    endtask

    assign pending = expected_prims.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] f[11];
        prim_state_t        e;
        if (!rst_n)
        begin
            gamma_m1 <= mhdc_pkg::GAMMA_RESET;
            expected_prims.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready) gamma_m1 <= cfg.data;
            if (cons.valid && cons.ready)
            begin
                f = '{cons.density, cons.momentum_x, cons.momentum_y, cons.momentum_z,
                      cons.field_x, cons.field_y, cons.field_z, cons.total_energy,
                      cons.cleaning_scalar, cons.eps_plus, cons.eps_minus};
                expected_prims.push_back(convert_cell(f, gamma_m1));
            end
            if (prim.valid && prim.ready)
            begin
                if (expected_prims.size() == 0)
                begin
                    $error("result item with no cell waiting for it");
                    fails++;
                end
                else
                begin
                    e = expected_prims.pop_front();
                    compare_field("density_out", e.density, prim.density_out);
                    compare_field("velocity_x", e.vel_x, prim.velocity_x);
                    compare_field("velocity_y", e.vel_y, prim.velocity_y);
                    compare_field("velocity_z", e.vel_z, prim.velocity_z);
                    compare_field("field_x_out", e.bx, prim.field_x_out);
                    compare_field("field_y_out", e.by, prim.field_y_out);
                    compare_field("field_z_out", e.bz, prim.field_z_out);
                    compare_field("pressure", e.pressure, prim.pressure);
                    compare_field("cleaning_scalar_out", e.psi, prim.cleaning_scalar_out);
                    compare_field("eps_plus_out", e.eps_p, prim.eps_plus_out);
                    compare_field("eps_minus_out", e.eps_m, prim.eps_minus_out);
                    compare_field("density_fault", 32'(e.fault), 32'(prim.density_fault));
                end
            end
        end
    end

    initial fails = 0;

endmodule

### tb/sv/mhd_conservative_to_primitive_test.sv
// ----------------------------------------------------------------------------
// mhd_conservative_to_primitive_test
// Drives directed and random cell states through the converter under several
// gamma settings, with random gaps and output stalls; the checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module mhd_conservative_to_primitive_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 72;
    localparam int WATCHDOG = 3000;

    logic clk;
    logic rst_n;
    logic calm;
    int   fails;
    int   pending;
    int   quiet;

    mhdc_cell_if #(.WORD_BITS(32)) cell_ch ();
    mhdc_prim_if #(.WORD_BITS(32)) prim_ch ();
    mhdc_cfg_if                    cfg_ch ();

    mhd_conservative_to_primitive #(.WORD_BITS(32), .FRACTION_BITS(16)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_in  (cell_ch),
        .prim_out (prim_ch),
        .cfg      (cfg_ch)
    );

    mhd_conservative_to_primitive_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .cons    (cell_ch),
        .prim    (prim_ch),
        .cfg     (cfg_ch),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic idle_now();
        return !calm && ($urandom_range(99) < 19);
    endfunction

    always @(posedge clk)
    begin
        prim_ch.ready <= rst_n && !idle_now();
    end

    // Any cycle with a handshake on some channel resets the watchdog.
    always @(posedge clk)
    begin
        if ((cell_ch.valid && cell_ch.ready) || (prim_ch.valid && prim_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("mhd_conservative_to_primitive_test NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] any_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] any_density();
        case ($urandom_range(9))
            0: return ($urandom_range(1) == 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
            1: return $urandom_range(255, 1);
            2: return $urandom();
            default: return $urandom_range(1 << 24, 1 << 12);
        endcase
    endfunction

    // Items are driven at the rising edge and ready is looked at mid-cycle.
    task automatic send_cell(logic [31:0] f[11]);
        while (idle_now())
        begin
            cell_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cell_ch.valid           <= 1'b1;
        cell_ch.density         <= f[0];
        cell_ch.momentum_x      <= f[1];
        cell_ch.momentum_y      <= f[2];
        cell_ch.momentum_z      <= f[3];
        cell_ch.field_x         <= f[4];
        cell_ch.field_y         <= f[5];
        cell_ch.field_z         <= f[6];
        cell_ch.total_energy    <= f[7];
        cell_ch.cleaning_scalar <= f[8];
        cell_ch.eps_plus        <= f[9];
        cell_ch.eps_minus       <= f[10];
        forever
        begin
            logic taken;
            @(negedge clk);
            taken = cell_ch.ready;
            @(posedge clk);
            if (taken) break;
        end
    endtask

    task automatic send_random_cell();
        logic [31:0] f[11];
        f[0] = any_density();
        for (int i = 1; i < 11; i++) f[i] = any_word();
        send_cell(f);
    endtask

    task automatic drain();
        cell_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_gamma(logic [mhdc_pkg::GAMMA_BITS-1:0] g);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= g;
        forever
        begin
            logic taken;
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
            if (taken) break;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0]                     f[11];
        logic [mhdc_pkg::GAMMA_BITS-1:0] gammas[6];
        rst_n   = 1'b0;
        calm    = 1'b0;
        cell_ch.valid = 1'b0;
        cell_ch.density = '0;
        cell_ch.momentum_x = '0;
        cell_ch.momentum_y = '0;
        cell_ch.momentum_z = '0;
        cell_ch.field_x = '0;
        cell_ch.field_y = '0;
        cell_ch.field_z = '0;
        cell_ch.total_energy = '0;
        cell_ch.cleaning_scalar = '0;
        cell_ch.eps_plus = '0;
        cell_ch.eps_minus = '0;
        prim_ch.ready = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells at the reset gamma: extremes, faults and saturation.
        for (int k = 0; k < 20; k++)
        begin
            for (int i = 0; i < 11; i++) f[i] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            case (k)
                0, 1: f[0] = 32'h0001_0000;
                2: f[0] = 32'd0;
                3: f[0] = 32'hFFFF_FFFF;
                4: f[0] = 32'h8000_0000;
                5: f[0] = 32'h7FFF_FFFF;
                6: f[0] = 32'd1;
                7: f[0] = 32'd1;
                8:
                begin
                    for (int i = 0; i < 11; i++) f[i] = '0;
                    f[0] = 32'h0001_0000;
                end
                9:
                begin
                    for (int i = 0; i < 11; i++) f[i] = '0;
                    f[0] = 32'h0002_0000;
                    f[1] = 32'h0003_0000;
                    f[2] = 32'hFFFD_0000;
                    f[7] = 32'h0010_0000;
                end
                default:
                begin
                    f[0] = any_density();
                    for (int i = 1; i < 11; i++) f[i] = any_word();
                end
            endcase
            send_cell(f);
        end
        drain();

        gammas = '{18'd0, 18'd131072, 18'h3FFFF, 18'($urandom()), mhdc_pkg::GAMMA_RESET,
                   18'($urandom_range(131072))};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_gamma(gammas[ph]);
            for (int n = 0; n < 240; n++)
            begin
                calm = (ph == 2) && (n >= 40) && (n < 200);
                send_random_cell();
            end
            calm = 1'b0;
            drain();
        end

        if (fails == 0)
            $display("mhd_conservative_to_primitive_test OK");
        else
            $display("mhd_conservative_to_primitive_test NOT OK");
        $finish;
    end

endmodule
